[sv/bgsc_pkg.sv]
// ----------------------------------------------------------------------------
// bgsc_pkg - brew group shot controller shared types
// transaction structs, decoded operation codes, led and stop cause codes
// ----------------------------------------------------------------------------
package bgsc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 32;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FLOW_CHECK_INTERVAL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTRACTION_TIMEOUT  = 1'd1;

	localparam logic [15:0] FLOW_CHECK_INTERVAL_RESET = 16'd100;
	localparam logic [31:0] EXTRACTION_TIMEOUT_RESET  = 32'd60000;

	// request kinds and button codes
	localparam logic       REQ_TICK   = 1'b0;
	localparam logic       REQ_BUTTON = 1'b1;
	localparam logic [1:0] BTN_STOP   = 2'd0;
	localparam logic [1:0] BTN_GO     = 2'd1;
	localparam logic [1:0] BTN_SINGLE = 2'd2;
	localparam logic [1:0] BTN_DOUBLE = 2'd3;
	localparam logic [1:0] EVT_PRESSED  = 2'd0;
	localparam logic [1:0] EVT_RELEASED = 2'd1;
	localparam logic [1:0] EVT_LONG     = 2'd2;
	localparam logic [1:0] EVT_UNKNOWN  = 2'd3;

	typedef enum logic [1:0] {
		LED_OFF   = 2'd0,
		LED_ON    = 2'd1,
		LED_BLINK = 2'd2
	} led_mode_t;

	typedef enum logic [2:0] {
		CAUSE_NONE    = 3'd0,
		CAUSE_SINGLE  = 3'd1,
		CAUSE_DOUBLE  = 3'd2,
		CAUSE_TIMEOUT = 3'd3,
		CAUSE_USER    = 3'd4
	} stop_cause_t;

	// decoded operation handed from front to back
	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_STOP_PRESS = 3'd1,
		OP_STOP_REL   = 3'd2,
		OP_STOP_LONG  = 3'd3,
		OP_GO_PRESS   = 3'd4,
		OP_GO_REL     = 3'd5,
		OP_DOSE_PRESS = 3'd6,
		OP_DOSE_REL   = 3'd7
	} op_t;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  button_id;
		logic [1:0]  event_kind;
		logic [31:0] now_ms;
		logic [15:0] flow_pulses;
	} req_item_t;

	typedef struct packed {
		logic        relay_on;
		logic        reset_flow;
		logic        save_settings;
		logic [1:0]  led_stop_mode;
		logic [1:0]  led_go_mode;
		logic [1:0]  led_single_mode;
		logic [1:0]  led_double_mode;
		logic [2:0]  stop_cause;
	} rsp_item_t;

	typedef struct packed {
		op_t         op;
		logic        dbl;
		logic [31:0] now_ms;
		logic [15:0] flow_pulses;
	} cmd_t;

endpackage

[sv/brew_group_shot_controller_unit.sv]
// ----------------------------------------------------------------------------
// brew_group_shot_controller_unit - brew group shot controller
// one brewing group: relay, four buttons with leds, flow pulse dosing,
// free extraction timeout and pulse target learning
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  transaction
//  req       req_valid req_stall req_data     in         tick or button event
//  rsp       rsp_valid rsp_stall rsp_data     out        one result per request
//  cfg       cfg_we cfg_index cfg_wdata       in         register write
//
// one transaction a cycle sustained while the result is not stalled; a request
// passes the queue write, then the execute step into the result register
// the execute step is combinational: event decode, a 32 bit elapsed time subtract
// and compare, flag and led updates
// reset clears all flags, leds, the queue and the result valid flag; the pulse
// targets come back to their defaults and the registers to their reset values
// a stalled result holds in the result register while the queue keeps taking
// requests; req_stall rises only when the two entry queue is full
//
module brew_group_shot_controller_unit #(
	parameter logic [15:0] DEFAULT_SINGLE_PULSES = 16'd200,
	parameter logic [15:0] DEFAULT_DOUBLE_PULSES = 16'd400
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  bgsc_pkg::req_item_t                req_data,
	// result channel
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output bgsc_pkg::rsp_item_t                rsp_data,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [bgsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bgsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// front to queue
	logic                 q_push;
	logic                 q_full;
	bgsc_pkg::cmd_t       q_wr_cmd;

	// queue to back
	logic                 q_pop;
	logic                 q_nonempty;
	bgsc_pkg::cmd_t       q_rd_cmd;

	// front: classify the event into a command
	bgsc_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_wr_cmd)
	);

	// queue decouples intake from execution
	bgsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (q_wr_cmd),
		.push     (q_push),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rd_cmd   (q_rd_cmd)
	);

	// back: group state, periodic check and result register
	bgsc_back #(
		.DEFAULT_SINGLE_PULSES (DEFAULT_SINGLE_PULSES),
		.DEFAULT_DOUBLE_PULSES (DEFAULT_DOUBLE_PULSES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.q_nonempty (q_nonempty),
		.cmd        (q_rd_cmd),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

	// stall mirrors queue full
	a_stall_is_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == q_full)
		else $error("request stall does not follow queue state");

endmodule

[sv/bgsc_front.sv]
// ----------------------------------------------------------------------------
// bgsc_front - request intake and classification
// decodes a tick or button event into one command for the queue
// ----------------------------------------------------------------------------
module bgsc_front (
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bgsc_pkg::req_item_t  req_data,
	input  logic                 q_full,
	output logic                 q_push,
	output bgsc_pkg::cmd_t       q_cmd
);

	bgsc_pkg::op_t op;

	always_comb begin
		op = bgsc_pkg::OP_TICK;
		if (req_data.req_type == bgsc_pkg::REQ_BUTTON) begin
			unique case (req_data.button_id)
				bgsc_pkg::BTN_STOP: begin
					unique case (req_data.event_kind)
						bgsc_pkg::EVT_PRESSED:  op = bgsc_pkg::OP_STOP_PRESS;
						bgsc_pkg::EVT_RELEASED: op = bgsc_pkg::OP_STOP_REL;
						bgsc_pkg::EVT_LONG:     op = bgsc_pkg::OP_STOP_LONG;
						default:                op = bgsc_pkg::OP_TICK;
					endcase
				end
				bgsc_pkg::BTN_GO: begin
					unique case (req_data.event_kind)
						bgsc_pkg::EVT_PRESSED:  op = bgsc_pkg::OP_GO_PRESS;
						bgsc_pkg::EVT_RELEASED: op = bgsc_pkg::OP_GO_REL;
						default:                op = bgsc_pkg::OP_TICK;
					endcase
				end
				default: begin
					unique case (req_data.event_kind)
						bgsc_pkg::EVT_PRESSED:  op = bgsc_pkg::OP_DOSE_PRESS;
						bgsc_pkg::EVT_RELEASED: op = bgsc_pkg::OP_DOSE_REL;
						default:                op = bgsc_pkg::OP_TICK;
					endcase
				end
			endcase
		end
	end

	assign q_cmd.op          = op;
	assign q_cmd.dbl         = (req_data.button_id == bgsc_pkg::BTN_DOUBLE);
	assign q_cmd.now_ms      = req_data.now_ms;
	assign q_cmd.flow_pulses = req_data.flow_pulses;

	assign req_stall = q_full;
	assign q_push    = req_valid & ~q_full;

endmodule

[sv/bgsc_queue.sv]
// ----------------------------------------------------------------------------
// bgsc_queue - command queue between front and back
// small register fifo, one push and one pop a cycle
// ----------------------------------------------------------------------------
module bgsc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bgsc_pkg::cmd_t         wr_cmd,
	input  logic                   push,
	input  logic                   pop,
	output logic                   full,
	output logic                   nonempty,
	output bgsc_pkg::cmd_t         rd_cmd
);

	localparam int unsigned PW = bgsc_pkg::QUEUE_PTR_W;
	localparam int unsigned CW = bgsc_pkg::QUEUE_CNT_W;
	localparam logic [CW-1:0] DEPTH = CW'(bgsc_pkg::QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST  = PW'(bgsc_pkg::QUEUE_DEPTH - 1);

	bgsc_pkg::cmd_t entry_q [bgsc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == DEPTH);
	assign nonempty = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");

endmodule

[sv/bgsc_back.sv]
// ----------------------------------------------------------------------------
// bgsc_back - shot execution and result register
// applies one command a cycle, unless the result is stalled, to the group state and registers the result
// ----------------------------------------------------------------------------
module bgsc_back #(
	parameter logic [15:0] DEFAULT_SINGLE_PULSES = 16'd200,
	parameter logic [15:0] DEFAULT_DOUBLE_PULSES = 16'd400
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bgsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bgsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 q_nonempty,
	input  bgsc_pkg::cmd_t                       cmd,
	output logic                                 q_pop,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output bgsc_pkg::rsp_item_t                  rsp_data
);

	logic [15:0] interval_q;
	logic [31:0] timeout_q;

	logic        ext_q, ds_q, dd_q, pm_q, pe_q, ps_q, pd_q;
	logic [15:0] single_tgt_q, double_tgt_q;
	logic [31:0] last_check_q;
	bgsc_pkg::led_mode_t led_stop_q, led_go_q, led_single_q, led_double_q;

	logic        n_ext, n_ds, n_dd, n_pm, n_pe, n_ps, n_pd;
	logic [15:0] n_single_tgt, n_double_tgt;
	logic [31:0] n_last_check;
	bgsc_pkg::led_mode_t n_led_stop, n_led_go, n_led_single, n_led_double;
	logic        n_reset_flow, n_save;
	bgsc_pkg::stop_cause_t n_cause;
	logic        learning;
	logic [31:0] elapsed;

	logic                rsp_valid_q;
	bgsc_pkg::rsp_item_t rsp_data_q;

	assign q_pop = q_nonempty & (~rsp_valid_q | ~rsp_stall);

	always_comb begin
		n_ext        = ext_q;
		n_ds         = ds_q;
		n_dd         = dd_q;
		n_pm         = pm_q;
		n_pe         = pe_q;
		n_ps         = ps_q;
		n_pd         = pd_q;
		n_single_tgt = single_tgt_q;
		n_double_tgt = double_tgt_q;
		n_last_check = last_check_q;
		n_led_stop   = led_stop_q;
		n_led_go     = led_go_q;
		n_led_single = led_single_q;
		n_led_double = led_double_q;
		n_reset_flow = 1'b0;
		n_save       = 1'b0;
		n_cause      = bgsc_pkg::CAUSE_NONE;
		learning     = cmd.dbl ? pd_q : ps_q;

		unique case (cmd.op)
			bgsc_pkg::OP_STOP_PRESS: begin
				if (!pm_q) n_led_stop = bgsc_pkg::LED_ON;
			end
			bgsc_pkg::OP_STOP_REL: begin
				if (!pm_q) begin
					n_led_stop = bgsc_pkg::LED_OFF;
					if (ext_q) begin
						n_ext        = 1'b0;
						n_ds         = 1'b0;
						n_dd         = 1'b0;
						n_led_stop   = bgsc_pkg::LED_OFF;
						n_led_go     = bgsc_pkg::LED_OFF;
						n_led_single = bgsc_pkg::LED_OFF;
						n_led_double = bgsc_pkg::LED_OFF;
						n_cause      = bgsc_pkg::CAUSE_USER;
					end
				end else if (pe_q) begin
					// learned target is the count at stop release
					n_led_go = bgsc_pkg::LED_OFF;
					if (ps_q) begin
						n_single_tgt = cmd.flow_pulses;
						n_save       = 1'b1;
					end else if (pd_q) begin
						n_double_tgt = cmd.flow_pulses;
						n_save       = 1'b1;
					end
					n_pm         = 1'b0;
					n_ps         = 1'b0;
					n_pd         = 1'b0;
					n_pe         = 1'b0;
					n_led_stop   = bgsc_pkg::LED_OFF;
					n_led_single = bgsc_pkg::LED_OFF;
					n_led_double = bgsc_pkg::LED_OFF;
				end
			end
			bgsc_pkg::OP_STOP_LONG: begin
				if (!pm_q) begin
					n_pm         = 1'b1;
					n_led_stop   = bgsc_pkg::LED_ON;
					n_led_single = bgsc_pkg::LED_BLINK;
					n_led_double = bgsc_pkg::LED_BLINK;
				end
			end
			bgsc_pkg::OP_GO_PRESS: begin
				if (!pm_q && !ext_q) n_led_go = bgsc_pkg::LED_ON;
			end
			bgsc_pkg::OP_GO_REL: begin
				if (!pm_q && !ext_q) begin
					n_last_check = cmd.now_ms;
					n_ext        = 1'b1;
					n_reset_flow = 1'b1;
					n_led_stop   = bgsc_pkg::LED_BLINK;
				end else if (pm_q) begin
					n_led_go     = bgsc_pkg::LED_ON;
					n_led_stop   = bgsc_pkg::LED_BLINK;
					n_reset_flow = 1'b1;
					n_pe         = 1'b1;
				end
			end
			bgsc_pkg::OP_DOSE_PRESS: begin
				if (!pm_q && !ext_q) begin
					if (cmd.dbl) n_led_double = bgsc_pkg::LED_ON;
					else         n_led_single = bgsc_pkg::LED_ON;
				end
			end
			bgsc_pkg::OP_DOSE_REL: begin
				if (!pm_q && !ext_q) begin
					n_last_check = cmd.now_ms;
					n_ext        = 1'b1;
					n_reset_flow = 1'b1;
					if (cmd.dbl) begin
						n_dd         = 1'b1;
						n_led_double = bgsc_pkg::LED_BLINK;
					end else begin
						n_ds         = 1'b1;
						n_led_single = bgsc_pkg::LED_BLINK;
					end
				end else if (!learning && pm_q) begin
					n_led_go = bgsc_pkg::LED_BLINK;
					if (cmd.dbl) begin
						n_led_double = bgsc_pkg::LED_ON;
						n_led_single = bgsc_pkg::LED_OFF;
						n_pd         = 1'b1;
					end else begin
						n_led_single = bgsc_pkg::LED_ON;
						n_led_double = bgsc_pkg::LED_OFF;
						n_ps         = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// periodic check runs on every command, after the event
		elapsed = cmd.now_ms - n_last_check;
		if (n_ext && (n_ds || n_dd)) begin
			if (elapsed > {16'd0, interval_q}) begin
				n_last_check = cmd.now_ms;
				if ((n_ds && cmd.flow_pulses >= n_single_tgt) ||
				    (n_dd && cmd.flow_pulses >= n_double_tgt)) begin
					n_cause      = (n_ds && cmd.flow_pulses >= n_single_tgt) ?
					               bgsc_pkg::CAUSE_SINGLE : bgsc_pkg::CAUSE_DOUBLE;
					n_ext        = 1'b0;
					n_ds         = 1'b0;
					n_dd         = 1'b0;
					n_led_stop   = bgsc_pkg::LED_OFF;
					n_led_go     = bgsc_pkg::LED_OFF;
					n_led_single = bgsc_pkg::LED_OFF;
					n_led_double = bgsc_pkg::LED_OFF;
				end
			end
		end else if (n_ext) begin
			if (elapsed > timeout_q) begin
				n_ext        = 1'b0;
				n_ds         = 1'b0;
				n_dd         = 1'b0;
				n_led_stop   = bgsc_pkg::LED_OFF;
				n_led_go     = bgsc_pkg::LED_OFF;
				n_led_single = bgsc_pkg::LED_OFF;
				n_led_double = bgsc_pkg::LED_OFF;
				n_cause      = bgsc_pkg::CAUSE_TIMEOUT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= bgsc_pkg::FLOW_CHECK_INTERVAL_RESET;
			timeout_q  <= bgsc_pkg::EXTRACTION_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bgsc_pkg::REG_FLOW_CHECK_INTERVAL: interval_q <= cfg_wdata[15:0];
				bgsc_pkg::REG_EXTRACTION_TIMEOUT:  timeout_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q        <= 1'b0;
			ds_q         <= 1'b0;
			dd_q         <= 1'b0;
			pm_q         <= 1'b0;
			pe_q         <= 1'b0;
			ps_q         <= 1'b0;
			pd_q         <= 1'b0;
			single_tgt_q <= DEFAULT_SINGLE_PULSES;
			double_tgt_q <= DEFAULT_DOUBLE_PULSES;
			last_check_q <= '0;
			led_stop_q   <= bgsc_pkg::LED_OFF;
			led_go_q     <= bgsc_pkg::LED_OFF;
			led_single_q <= bgsc_pkg::LED_OFF;
			led_double_q <= bgsc_pkg::LED_OFF;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				ext_q        <= n_ext;
				ds_q         <= n_ds;
				dd_q         <= n_dd;
				pm_q         <= n_pm;
				pe_q         <= n_pe;
				ps_q         <= n_ps;
				pd_q         <= n_pd;
				single_tgt_q <= n_single_tgt;
				double_tgt_q <= n_double_tgt;
				last_check_q <= n_last_check;
				led_stop_q   <= n_led_stop;
				led_go_q     <= n_led_go;
				led_single_q <= n_led_single;
				led_double_q <= n_led_double;
				rsp_valid_q  <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rsp_data_q.relay_on        <= n_ext;
			rsp_data_q.reset_flow      <= n_reset_flow;
			rsp_data_q.save_settings   <= n_save;
			rsp_data_q.led_stop_mode   <= n_led_stop;
			rsp_data_q.led_go_mode     <= n_led_go;
			rsp_data_q.led_single_mode <= n_led_single;
			rsp_data_q.led_double_mode <= n_led_double;
			rsp_data_q.stop_cause      <= n_cause;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	a_stop_clears_relay: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_data_q.stop_cause != bgsc_pkg::CAUSE_NONE)
		|-> !rsp_data_q.relay_on)
		else $error("extraction ended but relay still on");

	a_stop_clears_leds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && n_cause != bgsc_pkg::CAUSE_NONE) |=>
		(led_stop_q == bgsc_pkg::LED_OFF && led_go_q == bgsc_pkg::LED_OFF &&
		 led_single_q == bgsc_pkg::LED_OFF && led_double_q == bgsc_pkg::LED_OFF))
		else $error("leds not cleared at end of extraction");

	a_dosing_needs_relay: assert property (@(posedge clk) disable iff (!arst_n)
		(ds_q || dd_q) |-> ext_q)
		else $error("dosing flag set while not extracting");

endmodule
